// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the multi-pattern byte matcher.
// All of them sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPBM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpbm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MPBM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpbm assertion failed");

`endif

// ===== design/mpbm_pkg.sv =====
// ---------------------------------------------------------------------------
// mpbm_pkg
// Shared constants, codes and types of the multi-pattern byte matcher.
// ---------------------------------------------------------------------------
package mpbm_pkg;

  localparam int NUM_STATES_DEF      = 256;
  localparam int ALPHABET_SIZE_DEF   = 256;
  localparam int MAX_PATTERN_LEN_DEF = 64;
  localparam int RESULT_LIMIT        = 64;
  localparam int PAT_W               = 8;

  // Request codes.
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_BUILD  = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_MATCH    = 2'd0;
  localparam logic [1:0] ST_DONE     = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  // Per-field write enables of the node table.
  typedef struct packed {
    logic fail;
    logic outl;
    logic term;
    logic pat;
  } node_we_t;

  // Byte to symbol table: entry i holds i modulo alph, built by counting.
  function automatic logic [255:0][7:0] sym_mod_table(input int alph);
    logic [255:0][7:0] tbl;
    int r;
    r = 0;
    for (int i = 0; i < 256; i++) begin
      tbl[i] = 8'(r);
      if (r == alph - 1) begin
        r = 0;
      end else begin
        r = r + 1;
      end
    end
    return tbl;
  endfunction

endpackage

// ===== design/mpbm_child_mem.sv =====
// ---------------------------------------------------------------------------
// mpbm_child_mem
// Trie child table: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module mpbm_child_mem #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/mpbm_node_mem.sv =====
// ---------------------------------------------------------------------------
// mpbm_node_mem
// Per-node table: failure link, output link, terminal flag and pattern id,
// written field by field at one address and read together at another.
// ---------------------------------------------------------------------------
module mpbm_node_mem #(
  parameter int ADDR_W = 8
) (
  input  logic                   clk,
  input  mpbm_pkg::node_we_t     we,
  input  logic [ADDR_W-1:0]      waddr,
  input  logic [ADDR_W-1:0]      fail_wdata,
  input  logic [ADDR_W-1:0]      out_wdata,
  input  logic                   term_wdata,
  input  logic [mpbm_pkg::PAT_W-1:0] pat_wdata,
  input  logic                   re,
  input  logic [ADDR_W-1:0]      raddr,
  output logic [ADDR_W-1:0]      fail_rdata,
  output logic [ADDR_W-1:0]      out_rdata,
  output logic                   term_rdata,
  output logic [mpbm_pkg::PAT_W-1:0] pat_rdata
);

  import mpbm_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [ADDR_W-1:0] fail_mem [DEPTH];
  logic [ADDR_W-1:0] out_mem  [DEPTH];
  logic              term_mem [DEPTH];
  logic [PAT_W-1:0]  pat_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (we.fail) begin
      fail_mem[waddr] <= fail_wdata;
    end
    if (we.outl) begin
      out_mem[waddr] <= out_wdata;
    end
    if (we.term) begin
      term_mem[waddr] <= term_wdata;
    end
    if (we.pat) begin
      pat_mem[waddr] <= pat_wdata;
    end
    if (re) begin
      fail_rdata <= fail_mem[raddr];
      out_rdata  <= out_mem[raddr];
      term_rdata <= term_mem[raddr];
      pat_rdata  <= pat_mem[raddr];
    end
  end

endmodule

// ===== design/multi_pattern_byte_matcher_core.sv =====
// ---------------------------------------------------------------------------
// multi_pattern_byte_matcher_core
// Aho-Corasick matcher over a trie held in synchronous memories.
// ---------------------------------------------------------------------------
// Patterns are loaded one byte per transfer (add requests), a build request
// computes failure and output links breadth first and answers "build done",
// and each text byte (search request) gives one result per pattern ending at
// that byte, at most RESULT_LIMIT, the final one flagged with out_last. After
// reset the block clears the child table and the terminal flags, one entry
// per cycle, over all 2**(clog2(NUM_STATES) + clog2(ALPHABET_SIZE)) child
// table entries; in_stall stays high until then. The block works on one
// request at a time. An add request reads the child table, then writes any
// new node; a byte of a dropped pattern touches no table, and an add request
// that ends in an error result waits for the output register. A search
// request reads the child table, follows failure links through the node table
// while no child is found, then reads the node table once per match; each
// table has a single read port. A build walks every symbol of the alphabet
// for every queued node and the root, following failure links and reading
// the node table for each child found. A result waits in the output register
// while out_stall is high, and the next request is already taken in meanwhile.
// ---------------------------------------------------------------------------
module multi_pattern_byte_matcher_core #(
  parameter int NUM_STATES      = mpbm_pkg::NUM_STATES_DEF,
  parameter int ALPHABET_SIZE   = mpbm_pkg::ALPHABET_SIZE_DEF,
  parameter int MAX_PATTERN_LEN = mpbm_pkg::MAX_PATTERN_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_pattern_id,
  input  logic        in_pattern_end,
  input  logic        in_text_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_match_id,
  output logic [31:0] out_match_pos,
  output logic        out_last
);

  import mpbm_pkg::*;

`include "assert_macros.svh"

  // Node index, symbol, clear counter, depth and match counter widths.
  localparam int SW  = $clog2(NUM_STATES);
  localparam int AW  = $clog2(ALPHABET_SIZE);
  localparam int CW  = SW + AW;
  localparam int NCW = SW + 1;
  localparam int DW  = $clog2(MAX_PATTERN_LEN + 1);
  localparam int KW  = $clog2(RESULT_LIMIT);

  localparam logic [255:0][7:0] SYM_LUT = sym_mod_table(ALPHABET_SIZE);

  // Sequencer states.
  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_INS_D  = 5'd2;
  localparam logic [4:0] S_ERR    = 5'd3;
  localparam logic [4:0] S_B_UF   = 5'd4;
  localparam logic [4:0] S_B_UFD  = 5'd5;
  localparam logic [4:0] S_B_KRQ  = 5'd6;
  localparam logic [4:0] S_B_KD   = 5'd7;
  localparam logic [4:0] S_B_ARQ  = 5'd8;
  localparam logic [4:0] S_B_AD   = 5'd9;
  localparam logic [4:0] S_B_AF   = 5'd10;
  localparam logic [4:0] S_B_WD   = 5'd11;
  localparam logic [4:0] S_B_NXU  = 5'd12;
  localparam logic [4:0] S_B_QD   = 5'd13;
  localparam logic [4:0] S_B_DONE = 5'd14;
  localparam logic [4:0] S_S_ARQ  = 5'd15;
  localparam logic [4:0] S_S_AD   = 5'd16;
  localparam logic [4:0] S_S_AF   = 5'd17;
  localparam logic [4:0] S_S_TD   = 5'd18;
  localparam logic [4:0] S_S_OUT  = 5'd19;

  // Control state.
  logic [4:0]     state_r, state_nxt;
  logic [CW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [NCW-1:0] node_count_r, node_count_nxt;
  logic [SW-1:0]  cursor_r, cursor_nxt;
  logic [DW-1:0]  depth_r, depth_nxt;
  logic           broken_r, broken_nxt;
  logic [SW-1:0]  match_state_r, match_state_nxt;
  logic [31:0]    text_pos_r, text_pos_nxt;
  logic [NCW-1:0] head_r, head_nxt;
  logic [NCW-1:0] tail_r, tail_nxt;
  logic [KW-1:0]  cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;

  // Working registers of the current request.
  logic [AW-1:0]    sym_r, sym_nxt;
  logic [PAT_W-1:0] id_r, id_nxt;
  logic             end_r, end_nxt;
  logic [1:0]       err_code_r, err_code_nxt;
  logic [SW-1:0]    u_r, u_nxt;
  logic [SW-1:0]    fu_r, fu_nxt;
  logic [SW-1:0]    v_r, v_nxt;
  logic [SW-1:0]    walk_r, walk_nxt;
  logic [SW-1:0]    w_r, w_nxt;
  logic [31:0]      pos_r, pos_nxt;

  // Output register payload.
  logic [1:0]       out_status_r, out_status_nxt;
  logic [PAT_W-1:0] out_id_r, out_id_nxt;
  logic [31:0]      out_pos_r, out_pos_nxt;
  logic             out_last_r, out_last_nxt;

  // Memory ports.
  logic          ch_we, ch_re;
  logic [CW-1:0] ch_waddr, ch_raddr;
  logic [SW-1:0] ch_wdata, ch_rdata;

  node_we_t         nd_we;
  logic [SW-1:0]    nd_waddr, nd_raddr;
  logic [SW-1:0]    nd_fail_w, nd_out_w;
  logic             nd_term_w, nd_re;
  logic [PAT_W-1:0] nd_pat_w;
  logic [SW-1:0]    nd_fail_rd, nd_out_rd;
  logic             nd_term_rd;
  logic [PAT_W-1:0] nd_pat_rd;

  // Breadth-first queue of nodes whose children still need links.
  localparam int QDEPTH = 1 << SW;
  logic [SW-1:0] queue_mem [QDEPTH];
  logic          q_we, q_re;
  logic [SW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rdata <= queue_mem[q_raddr];
    end
  end

  mpbm_child_mem #(
    .ADDR_W (CW),
    .DATA_W (SW)
  ) u_child_mem (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_waddr),
    .wdata (ch_wdata),
    .re    (ch_re),
    .raddr (ch_raddr),
    .rdata (ch_rdata)
  );

  mpbm_node_mem #(
    .ADDR_W (SW)
  ) u_node_mem (
    .clk        (clk),
    .we         (nd_we),
    .waddr      (nd_waddr),
    .fail_wdata (nd_fail_w),
    .out_wdata  (nd_out_w),
    .term_wdata (nd_term_w),
    .pat_wdata  (nd_pat_w),
    .re         (nd_re),
    .raddr      (nd_raddr),
    .fail_rdata (nd_fail_rd),
    .out_rdata  (nd_out_rd),
    .term_rdata (nd_term_rd),
    .pat_rdata  (nd_pat_rd)
  );

  // The incoming byte folded into the alphabet.
  logic [AW-1:0] in_sym;
  assign in_sym = SYM_LUT[in_data_byte][AW-1:0];

  // The output register can take a new result this cycle.
  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // Only the idle state takes a request.
  assign in_stall = (state_r != S_IDLE);

  logic [31:0]   pos_base;
  logic [SW-1:0] new_node;
  logic [SW-1:0] w_adj;
  logic [SW-1:0] t_first;
  logic          chain_end;

  assign pos_base  = in_text_start ? 32'd0 : text_pos_r;
  assign new_node  = (ch_rdata == '0) ? node_count_r[SW-1:0] : ch_rdata;
  // A failure target equal to the child itself only arises below the root,
  // where the child's failure link is the root.
  assign w_adj     = (ch_rdata == v_r) ? '0 : ch_rdata;
  assign t_first   = nd_term_rd ? match_state_r : nd_out_rd;
  assign chain_end = (nd_out_rd == '0) || (cnt_r == KW'(RESULT_LIMIT - 1));

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    node_count_nxt  = node_count_r;
    cursor_nxt      = cursor_r;
    depth_nxt       = depth_r;
    broken_nxt      = broken_r;
    match_state_nxt = match_state_r;
    text_pos_nxt    = text_pos_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    cnt_nxt         = cnt_r;
    sym_nxt         = sym_r;
    id_nxt          = id_r;
    end_nxt         = end_r;
    err_code_nxt    = err_code_r;
    u_nxt           = u_r;
    fu_nxt          = fu_r;
    v_nxt           = v_r;
    walk_nxt        = walk_r;
    w_nxt           = w_r;
    pos_nxt         = pos_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;

    ch_we     = 1'b0;
    ch_waddr  = '0;
    ch_wdata  = '0;
    ch_re     = 1'b0;
    ch_raddr  = '0;
    nd_we     = '0;
    nd_waddr  = '0;
    nd_fail_w = '0;
    nd_out_w  = '0;
    nd_term_w = 1'b0;
    nd_pat_w  = '0;
    nd_re     = 1'b0;
    nd_raddr  = '0;
    q_we      = 1'b0;
    q_waddr   = '0;
    q_wdata   = '0;
    q_re      = 1'b0;
    q_raddr   = '0;

    case (state_r)
      S_CLEAR: begin
        ch_we    = 1'b1;
        ch_waddr = clr_cnt_r;
        if (clr_cnt_r[CW-1:SW] == '0) begin
          nd_we.term = 1'b1;
          nd_waddr   = clr_cnt_r[SW-1:0];
        end
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          sym_nxt = in_sym;
          id_nxt  = in_pattern_id;
          end_nxt = in_pattern_end;
          case (in_req_type)
            REQ_ADD: begin
              if (broken_r) begin
                // The rest of a broken pattern is dropped up to its end.
                if (in_pattern_end) begin
                  cursor_nxt = '0;
                  depth_nxt  = '0;
                  broken_nxt = 1'b0;
                end
              end else if (depth_r >= DW'(MAX_PATTERN_LEN)) begin
                err_code_nxt = ST_TOO_LONG;
                state_nxt    = S_ERR;
              end else begin
                ch_re     = 1'b1;
                ch_raddr  = {cursor_r, in_sym};
                state_nxt = S_INS_D;
              end
            end
            REQ_BUILD: begin
              // The root's links are the root; then the root itself is
              // walked like any queued node, with failure link zero.
              nd_we.fail = 1'b1;
              nd_we.outl = 1'b1;
              nd_waddr   = '0;
              u_nxt      = '0;
              fu_nxt     = '0;
              sym_nxt    = '0;
              head_nxt   = '0;
              tail_nxt   = '0;
              state_nxt  = S_B_KRQ;
            end
            REQ_SEARCH: begin
              pos_nxt      = pos_base;
              text_pos_nxt = (&pos_base) ? pos_base : pos_base + 32'd1;
              walk_nxt     = in_text_start ? '0 : match_state_r;
              state_nxt    = S_S_ARQ;
            end
            default: begin
            end
          endcase
        end
      end

      S_INS_D: begin
        if ((ch_rdata == '0) && (node_count_r >= NCW'(NUM_STATES))) begin
          err_code_nxt = ST_FULL;
          state_nxt    = S_ERR;
        end else begin
          if (ch_rdata == '0) begin
            ch_we          = 1'b1;
            ch_waddr       = {cursor_r, sym_r};
            ch_wdata       = node_count_r[SW-1:0];
            node_count_nxt = node_count_r + 1'b1;
          end
          cursor_nxt = new_node;
          depth_nxt  = depth_r + 1'b1;
          if (end_r) begin
            nd_we.term = 1'b1;
            nd_we.pat  = 1'b1;
            nd_waddr   = new_node;
            nd_term_w  = 1'b1;
            nd_pat_w   = id_r;
            cursor_nxt = '0;
            depth_nxt  = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      S_ERR: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = err_code_r;
          out_id_nxt     = '0;
          out_pos_nxt    = '0;
          out_last_nxt   = 1'b1;
          broken_nxt     = 1'b1;
          if (end_r) begin
            cursor_nxt = '0;
            depth_nxt  = '0;
            broken_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end

      S_B_UF: begin
        nd_re     = 1'b1;
        nd_raddr  = u_r;
        state_nxt = S_B_UFD;
      end

      S_B_UFD: begin
        fu_nxt    = nd_fail_rd;
        sym_nxt   = '0;
        state_nxt = S_B_KRQ;
      end

      S_B_KRQ: begin
        ch_re     = 1'b1;
        ch_raddr  = {u_r, sym_r};
        state_nxt = S_B_KD;
      end

      S_B_KD: begin
        if (ch_rdata != '0) begin
          v_nxt     = ch_rdata;
          walk_nxt  = fu_r;
          state_nxt = S_B_ARQ;
        end else if (sym_r == AW'(ALPHABET_SIZE - 1)) begin
          state_nxt = S_B_NXU;
        end else begin
          sym_nxt   = sym_r + 1'b1;
          state_nxt = S_B_KRQ;
        end
      end

      S_B_ARQ: begin
        ch_re     = 1'b1;
        ch_raddr  = {walk_r, sym_r};
        state_nxt = S_B_AD;
      end

      S_B_AD: begin
        if ((ch_rdata != '0) || (walk_r == '0)) begin
          w_nxt     = w_adj;
          nd_re     = 1'b1;
          nd_raddr  = w_adj;
          state_nxt = S_B_WD;
        end else begin
          nd_re     = 1'b1;
          nd_raddr  = walk_r;
          state_nxt = S_B_AF;
        end
      end

      S_B_AF: begin
        walk_nxt  = nd_fail_rd;
        state_nxt = S_B_ARQ;
      end

      S_B_WD: begin
        nd_we.fail = 1'b1;
        nd_we.outl = 1'b1;
        nd_waddr   = v_r;
        nd_fail_w  = w_r;
        nd_out_w   = nd_term_rd ? w_r : nd_out_rd;
        q_we       = 1'b1;
        q_waddr    = tail_r[SW-1:0];
        q_wdata    = v_r;
        tail_nxt   = tail_r + 1'b1;
        if (sym_r == AW'(ALPHABET_SIZE - 1)) begin
          state_nxt = S_B_NXU;
        end else begin
          sym_nxt   = sym_r + 1'b1;
          state_nxt = S_B_KRQ;
        end
      end

      S_B_NXU: begin
        if (head_r < tail_r) begin
          q_re      = 1'b1;
          q_raddr   = head_r[SW-1:0];
          head_nxt  = head_r + 1'b1;
          state_nxt = S_B_QD;
        end else begin
          state_nxt = S_B_DONE;
        end
      end

      S_B_QD: begin
        u_nxt     = q_rdata;
        state_nxt = S_B_UF;
      end

      S_B_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DONE;
          out_id_nxt     = '0;
          out_pos_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_S_ARQ: begin
        ch_re     = 1'b1;
        ch_raddr  = {walk_r, sym_r};
        state_nxt = S_S_AD;
      end

      S_S_AD: begin
        if ((ch_rdata != '0) || (walk_r == '0)) begin
          match_state_nxt = ch_rdata;
          nd_re           = 1'b1;
          nd_raddr        = ch_rdata;
          state_nxt       = S_S_TD;
        end else begin
          nd_re     = 1'b1;
          nd_raddr  = walk_r;
          state_nxt = S_S_AF;
        end
      end

      S_S_AF: begin
        walk_nxt  = nd_fail_rd;
        state_nxt = S_S_ARQ;
      end

      S_S_TD: begin
        cnt_nxt = '0;
        if (t_first == '0) begin
          state_nxt = S_IDLE;
        end else begin
          nd_re     = 1'b1;
          nd_raddr  = t_first;
          state_nxt = S_S_OUT;
        end
      end

      S_S_OUT: begin
        // The node read stays in place while the output register is full.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_MATCH;
          out_id_nxt     = nd_pat_rd;
          out_pos_nxt    = pos_r;
          out_last_nxt   = chain_end;
          cnt_nxt        = cnt_r + 1'b1;
          if (chain_end) begin
            state_nxt = S_IDLE;
          end else begin
            nd_re    = 1'b1;
            nd_raddr = nd_out_rd;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_cnt_r     <= '0;
      node_count_r  <= NCW'(1);
      cursor_r      <= '0;
      depth_r       <= '0;
      broken_r      <= 1'b0;
      match_state_r <= '0;
      text_pos_r    <= '0;
      head_r        <= '0;
      tail_r        <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      node_count_r  <= node_count_nxt;
      cursor_r      <= cursor_nxt;
      depth_r       <= depth_nxt;
      broken_r      <= broken_nxt;
      match_state_r <= match_state_nxt;
      text_pos_r    <= text_pos_nxt;
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r        <= sym_nxt;
    id_r         <= id_nxt;
    end_r        <= end_nxt;
    err_code_r   <= err_code_nxt;
    u_r          <= u_nxt;
    fu_r         <= fu_nxt;
    v_r          <= v_nxt;
    walk_r       <= walk_nxt;
    w_r          <= w_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_match_id  = out_id_r;
  assign out_match_pos = out_pos_r;
  assign out_last      = out_last_r;

  // No result can appear while the tables are being cleared.
  `MPBM_ASSERT_IMP(a_clear_quiet, state_r == S_CLEAR, !out_valid_r)
  // A result that is not the last one is only ever a match with more to come.
  `MPBM_ASSERT_IMP(a_more_follows, out_valid_r && !out_last_r, state_r == S_S_OUT)
  // A new trie node advances the node count by exactly one.
  `MPBM_ASSERT_NXT(a_node_grow,
    (state_r == S_INS_D) && (ch_rdata == '0) && (node_count_r < NCW'(NUM_STATES)),
    node_count_r == $past(node_count_r) + 1'b1)
  // The queue is never read past what has been written.
  `MPBM_ASSERT_IMP(a_queue_order, state_r != S_CLEAR, head_r <= tail_r)

endmodule

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking testbench for multi_pattern_byte_matcher_core.
// ---------------------------------------------------------------------------
// Patterns are loaded, links are built and text is scanned in several rounds.
// A scoreboard keeps its own copy of the trie and predicts every result,
// including table overflow and overlong patterns. Both handshakes idle at
// random, and the result side holds off for one long stretch.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mpbm_pkg::*;

  // Request code 3 is not used by the block; it must be ignored.
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int unsigned SAT_POS = 32'hFFFF_FFFF;

  // Scoreboard: shadow trie plus the queue of results still owed by the block.
  class match_scoreboard;
    typedef struct {
      logic [1:0]  status;
      logic [7:0]  id;
      logic [31:0] pos;
      logic        last;
    } hit_t;

    hit_t        owed_q[$];
    int          errors;
    logic [7:0]  child [65536];
    logic [7:0]  fail_of [256];
    logic [7:0]  out_of [256];
    logic [7:0]  pat_of [256];
    bit          term [256];
    int unsigned nodes, cursor, depth, mstate;
    logic [31:0] tpos;
    bit          broken;

    function new();
      foreach (child[i]) child[i] = '0;
      foreach (term[i]) begin
        term[i] = 0;
        fail_of[i] = '0;
        out_of[i] = '0;
        pat_of[i] = '0;
      end
      nodes = 1;
      cursor = 0;
      depth = 0;
      mstate = 0;
      tpos = '0;
      broken = 0;
      errors = 0;
    endfunction

    function int unsigned kid(int unsigned n, int unsigned s);
      return child[n * 256 + s];
    endfunction

    // Walk failure links until some node has a child on s.
    function int unsigned follow(int unsigned node, int unsigned s);
      int unsigned g;
      g = 0;
      while (node != 0 && kid(node, s) == 0 && g < NUM_STATES_DEF) begin
        node = fail_of[node];
        g++;
      end
      return kid(node, s);
    endfunction

    function void owe(logic [1:0] st, logic [7:0] id, logic [31:0] pos, logic lst);
      hit_t h;
      h.status = st;
      h.id = id;
      h.pos = pos;
      h.last = lst;
      owed_q.insert(owed_q.size(), h);
    endfunction

    function void add_byte(int unsigned b, logic [7:0] id, logic pend);
      int unsigned c;
      if (!broken) begin
        if (depth >= MAX_PATTERN_LEN_DEF) begin
          owe(ST_TOO_LONG, 0, 0, 1);
          broken = 1;
        end else begin
          c = kid(cursor, b);
          if (c == 0) begin
            if (nodes >= NUM_STATES_DEF) begin
              owe(ST_FULL, 0, 0, 1);
              broken = 1;
            end else begin
              c = nodes;
              child[cursor * 256 + b] = c[7:0];
              nodes++;
            end
          end
          if (!broken) begin
            cursor = c;
            depth++;
            if (pend) begin
              term[c] = 1;
              pat_of[c] = id;
            end
          end
        end
      end
      if (pend) begin
        cursor = 0;
        depth = 0;
        broken = 0;
      end
    endfunction

    function void build_links();
      int unsigned q [256];
      int unsigned head, tail, u, v, w, c;
      head = 0;
      tail = 0;
      fail_of[0] = 0;
      out_of[0] = 0;
      for (int s = 0; s < 256; s++) begin
        c = kid(0, s);
        if (c != 0 && tail < NUM_STATES_DEF) begin
          fail_of[c] = 0;
          out_of[c] = 0;
          q[tail++] = c;
        end
      end
      while (head < tail) begin
        u = q[head++];
        for (int s = 0; s < 256; s++) begin
          v = kid(u, s);
          if (v == 0 || tail >= NUM_STATES_DEF) continue;
          w = follow(fail_of[u], s);
          if (w == v) w = 0;
          fail_of[v] = w[7:0];
          out_of[v] = term[w] ? w[7:0] : out_of[w];
          q[tail++] = v;
        end
      end
    endfunction

    function void scan(int unsigned b, logic pstart);
      int unsigned t;
      int n;
      logic [31:0] p;
      if (pstart) begin
        mstate = 0;
        tpos = '0;
      end
      p = tpos;
      if (tpos != SAT_POS) tpos++;
      mstate = follow(mstate, b);
      t = term[mstate] ? mstate : out_of[mstate];
      n = 0;
      while (t != 0 && n < RESULT_LIMIT) begin
        owe(ST_MATCH, pat_of[t], p, 0);
        n++;
        t = out_of[t];
      end
      if (n > 0) owed_q[owed_q.size() - 1].last = 1;
    endfunction

    // Called for every accepted input transfer.
    function void note(logic [1:0] req, logic [7:0] b, logic [7:0] id,
                       logic pend, logic pstart);
      case (req)
        REQ_ADD: add_byte(b, id, pend);
        REQ_BUILD: begin
          build_links();
          owe(ST_DONE, 0, 0, 1);
        end
        REQ_SEARCH: scan(b, pstart);
        default: ;
      endcase
    endfunction

    function void field_diff(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    // Called for every accepted result transfer.
    function void check(logic [1:0] st, logic [7:0] id, logic [31:0] pos, logic lst);
      hit_t e;
      if (owed_q.size() == 0) begin
        $display({"%0t: unexpected result, expected none, ",
                  "actual status=%0d id=%0d pos=%0d last=%0d"},
                 $time, st, id, pos, lst);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      field_diff("status", e.status, st);
      field_diff("match_id", e.id, id);
      field_diff("match_pos", e.pos, pos);
      field_diff("last", e.last, lst);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_NONE;
  logic [7:0]  in_data_byte = '0;
  logic [7:0]  in_pattern_id = '0;
  logic        in_pattern_end = 0;
  logic        in_text_start = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  out_status;
  logic [7:0]  out_match_id;
  logic [31:0] out_match_pos;
  logic        out_last;

  match_scoreboard sb = new();

  // When calm is set neither side idles; hold_req asks the result side for
  // one long hold-off while the sender keeps offering transfers.
  bit calm = 0;
  bit hold_req = 0;

  multi_pattern_byte_matcher_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_data_byte(in_data_byte),
    .in_pattern_id(in_pattern_id), .in_pattern_end(in_pattern_end),
    .in_text_start(in_text_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_match_id(out_match_id),
    .out_match_pos(out_match_pos), .out_last(out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one input transfer and return at the edge where it is taken.
  // Values sampled right after the edge are the ones the block saw there.
  task automatic send(logic [1:0] req, logic [7:0] b, logic [7:0] id,
                      logic pend, logic pstart);
    if (!calm) begin
      while ($urandom_range(99) < 37) begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    in_valid <= 1;
    in_req_type <= req;
    in_data_byte <= b;
    in_pattern_id <= id;
    in_pattern_end <= pend;
    in_text_start <= pstart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note(req, b, id, pend, pstart);
  endtask

  function automatic logic [7:0] pick_byte(bit wide);
    return wide ? 8'($urandom_range(255)) : 8'("a" + $urandom_range(3));
  endfunction

  task automatic add_text(string s, logic [7:0] id);
    for (int i = 0; i < s.len(); i++) send(REQ_ADD, s[i], id, i == s.len() - 1, 0);
  endtask

  task automatic add_random(int len, bit wide);
    logic [7:0] id;
    id = 8'($urandom_range(255));
    for (int i = 0; i < len; i++) send(REQ_ADD, pick_byte(wide), id, i == len - 1, 0);
  endtask

  // Scan a random text; most bytes come from a small alphabet so that the
  // loaded patterns actually hit, with some noise requests mixed in.
  task automatic search_random(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) begin
        send(REQ_NONE, 8'($urandom_range(255)), 8'($urandom_range(255)),
             1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      send(REQ_SEARCH, pick_byte($urandom_range(99) < 20), 8'($urandom_range(255)),
           1'($urandom_range(1)), i == 0 || $urandom_range(99) < 5);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: check each transfer, then choose the next stall value.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check(out_status, out_match_id, out_match_pos, out_last);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1;
      end else begin
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 37);
      end
    end
  end

  // Stimulus.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;

    // Directed part: overlapping patterns, a repeated pattern under a new id,
    // extreme bytes, an ignored request code, one build and a short scan.
    add_text("he", 8'd1);
    add_text("she", 8'd2);
    add_text("hers", 8'd4);
    send(REQ_ADD, 8'h00, 8'h00, 1, 1);
    send(REQ_ADD, 8'hFF, 8'hFF, 0, 0);
    send(REQ_ADD, 8'h80, 8'hFF, 1, 0);
    add_text("he", 8'd9);
    send(REQ_NONE, 8'hFF, 8'hFF, 1, 1);
    send(REQ_BUILD, 8'h00, 8'h00, 0, 0);
    send(REQ_SEARCH, "u", 8'h00, 0, 1);
    send(REQ_SEARCH, "s", 8'h00, 0, 0);
    send(REQ_SEARCH, "h", 8'h00, 0, 0);
    send(REQ_SEARCH, "e", 8'h00, 0, 0);
    send(REQ_SEARCH, "r", 8'h00, 0, 0);
    send(REQ_SEARCH, "s", 8'h00, 0, 0);
    send(REQ_SEARCH, 8'h00, 8'hFF, 1, 0);
    send(REQ_SEARCH, 8'hFF, 8'hFF, 1, 0);
    send(REQ_SEARCH, 8'h80, 8'h00, 0, 0);
    // The sender waits here until every owed result has come back.
    drain();

    // Round one: short patterns, then a scan under a long result hold-off.
    for (int i = 0; i < 4; i++) add_random($urandom_range(1, 5), 0);
    send(REQ_BUILD, 8'($urandom_range(255)), 8'($urandom_range(255)), 0, 0);
    hold_req = 1;
    search_random(50);

    // Round two, without idling: one overlong pattern and a few short ones.
    calm = 1;
    add_random(MAX_PATTERN_LEN_DEF + 2, 1);
    for (int i = 0; i < 3; i++) add_random($urandom_range(2, 4), 0);
    send(REQ_BUILD, 8'h00, 8'h00, 0, 0);
    search_random(50);
    calm = 0;

    // Round three: fill the node table, then overflow it once more.
    while (sb.nodes < NUM_STATES_DEF) add_random(32, 1);
    add_random(3, 1);
    add_random(2, 0);
    send(REQ_BUILD, 8'hFF, 8'hFF, 1, 1);
    search_random(50);

    // Round four: table already full; loads mostly fail, scans still match.
    add_random(3, 0);
    add_random(2, 1);
    send(REQ_BUILD, 8'h00, 8'h00, 0, 0);
    search_random(40);

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[multi_pattern_byte_matcher_core] OK");
    end else begin
      $display("[multi_pattern_byte_matcher_core] ERROR");
    end
    $finish;
  end

  // Watchdog: stops the run with an error if the clearing pass, the five builds
  // and all scans have not finished by then.
  initial begin
    #100_000_000;
    $display("[multi_pattern_byte_matcher_core] ERROR");
    $finish;
  end

endmodule
